// ----- sv/pbd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbd_pkg
// Shared widths, constants, reset values and register indexes of the pulse
// beat detector.
// ----------------------------------------------------------------------------
package pbd_pkg;

    // field widths
    localparam int SAMPLE_W = 10;
    localparam int TIME_W   = 16;
    localparam int PERIOD_W = 4;
    localparam int REFR_W   = 12;
    localparam int TOUT_W   = 15;

    // interval history
    localparam int HIST_DEPTH = 10;
    localparam int HCNT_W     = $clog2(HIST_DEPTH + 1);
    localparam int SUM_W      = TIME_W + $clog2(HIST_DEPTH);

    // shared serial divider
    localparam int DIV_W  = SUM_W;
    localparam int DCNT_W = $clog2(DIV_W + 1);

    localparam int MS_PER_MINUTE = 60000;
    localparam int GUARD_DIV     = 5;

    // configuration port
    localparam int CFG_DW = 32;
    localparam int CFG_AW = 5;
    localparam int CFG_IW = 3;

    localparam logic [CFG_IW-1:0] REG_PERIOD     = 3'd0;
    localparam logic [CFG_IW-1:0] REG_REFRACTORY = 3'd1;
    localparam logic [CFG_IW-1:0] REG_TIMEOUT    = 3'd2;
    localparam logic [CFG_IW-1:0] REG_DEF_THR    = 3'd3;
    localparam logic [CFG_IW-1:0] REG_DEF_LVL    = 3'd4;

    // reset values
    localparam logic [PERIOD_W-1:0] RST_PERIOD     = 4'd2;
    localparam logic [REFR_W-1:0]   RST_REFRACTORY = 12'd250;
    localparam logic [TOUT_W-1:0]   RST_TIMEOUT    = 15'd2500;
    localparam logic [SAMPLE_W-1:0] RST_DEF_THR    = 10'd530;
    localparam logic [SAMPLE_W-1:0] RST_DEF_LVL    = 10'd512;
    localparam logic [TIME_W-1:0]   RST_INTERVAL   = 16'd600;
    // (600 / 5) * 3
    localparam logic [TIME_W-1:0]   RST_GUARD      = 16'd360;

endpackage

// ----- sv/pbd_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbd_in_if
// Sample channel: valid/ready handshake carrying one converter sample.
// ----------------------------------------------------------------------------
interface pbd_in_if import pbd_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);

endinterface

// ----- sv/pbd_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbd_out_if
// Result channel: valid/ready handshake carrying one detector result.
// ----------------------------------------------------------------------------
interface pbd_out_if import pbd_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [TIME_W-1:0]   bpm;
    logic                beat_found;
    logic                pulse_active;
    logic [TIME_W-1:0]   interval_ms;
    logic [SAMPLE_W-1:0] level_threshold;
    logic [SAMPLE_W-1:0] amplitude;

    modport source (
        output valid, output bpm, output beat_found, output pulse_active,
        output interval_ms, output level_threshold, output amplitude,
        input ready
    );
    modport sink (
        input valid, input bpm, input beat_found, input pulse_active,
        input interval_ms, input level_threshold, input amplitude,
        output ready
    );

endinterface

// ----- sv/pulse_beat_detector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_beat_detector
// Adaptive-threshold heart beat detector for an optical pulse waveform.
// ----------------------------------------------------------------------------
// One result item is returned for every sample item. A sample that is not a
// beat goes from the update straight to the result register. A first beat
// runs the guard division before its result; a counted beat then also runs
// the history sum, the mean and, for a nonzero mean, the rate division. All
// divisions run through one shared restoring divider that retires one quotient
// bit a cycle, used in turn for the 3/5 interval guard, the history mean and
// 60000 / mean, while the history sum is taken one entry a cycle by rotating
// the history shift line. A new sample is taken once the previous item has
// reached the result register, even while that result still waits to be taken.
module pulse_beat_detector import pbd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    pbd_in_if.sink            i_in,
    pbd_out_if.source         o_out
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_GUARD = 3'd1;
    localparam logic [2:0] ST_SUM   = 3'd2;
    localparam logic [2:0] ST_MEAN  = 3'd3;
    localparam logic [2:0] ST_RATE  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    // configuration
    logic [PERIOD_W-1:0] r_period;
    logic [REFR_W-1:0]   r_refr;
    logic [TOUT_W-1:0]   r_timeout;
    logic [SAMPLE_W-1:0] r_def_thr;
    logic [SAMPLE_W-1:0] r_def_lvl;

    // detector state
    logic [2:0]          r_state;
    logic [TIME_W-1:0]   r_elapsed;
    logic [TIME_W-1:0]   r_last;
    logic [TIME_W-1:0]   r_guard;
    logic [SAMPLE_W-1:0] r_peak;
    logic [SAMPLE_W-1:0] r_trough;
    logic [SAMPLE_W-1:0] r_thr;
    logic [SAMPLE_W-1:0] r_amp;
    logic                r_in_pulse;
    logic                r_await_first;
    logic                r_await_second;
    logic                r_found;
    logic [TIME_W-1:0]   r_rate;
    logic [TIME_W-1:0]   r_hist [HIST_DEPTH];
    logic [HCNT_W-1:0]   r_hcnt;
    logic [SUM_W-1:0]    r_acc;

    // serial divider
    logic [DCNT_W-1:0]   r_dcnt;
    logic [DIV_W-1:0]    r_quo;
    logic [TIME_W-1:0]   r_rem;
    logic [TIME_W-1:0]   r_dsor;

    // result register
    logic                r_ovalid;
    logic [TIME_W-1:0]   r_obpm;
    logic                r_ofound;
    logic                r_opulse;
    logic [TIME_W-1:0]   r_ointerval;
    logic [SAMPLE_W-1:0] r_othr;
    logic [SAMPLE_W-1:0] r_oamp;

    logic                cfg_wr;
    logic [CFG_IW-1:0]   cfg_idx;
    logic                in_acc;
    logic                out_load;

    logic [TIME_W:0]     elapsed_sum;
    logic [TIME_W-1:0]   elapsed_inc;
    logic [SAMPLE_W-1:0] s;
    logic                s_lo;
    logic                s_hi;
    logic [SAMPLE_W-1:0] trough_a;
    logic [SAMPLE_W-1:0] peak_a;
    logic                beat;
    logic                first;
    logic                fall;
    logic                tout;
    logic [SAMPLE_W-1:0] amp_f;
    logic [SAMPLE_W:0]   thr_sum;
    logic [SAMPLE_W-1:0] thr_f;

    logic [TIME_W:0]     div_trial;
    logic                div_ge;
    logic [TIME_W-1:0]   n_rem;
    logic [TIME_W-1:0]   quo_lo;
    logic [TIME_W+1:0]   guard3;
    logic                div_start;
    logic [DIV_W-1:0]    div_dividend;
    logic [TIME_W-1:0]   div_divisor;
    logic                sum_start;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[CFG_AW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= RST_PERIOD;
            r_refr    <= RST_REFRACTORY;
            r_timeout <= RST_TIMEOUT;
            r_def_thr <= RST_DEF_THR;
            r_def_lvl <= RST_DEF_LVL;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_PERIOD:     r_period  <= pwdata[PERIOD_W-1:0];
                REG_REFRACTORY: r_refr    <= pwdata[REFR_W-1:0];
                REG_TIMEOUT:    r_timeout <= pwdata[TOUT_W-1:0];
                REG_DEF_THR:    r_def_thr <= pwdata[SAMPLE_W-1:0];
                REG_DEF_LVL:    r_def_lvl <= pwdata[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_PERIOD:     prdata = CFG_DW'(r_period);
            REG_REFRACTORY: prdata = CFG_DW'(r_refr);
            REG_TIMEOUT:    prdata = CFG_DW'(r_timeout);
            REG_DEF_THR:    prdata = CFG_DW'(r_def_thr);
            REG_DEF_LVL:    prdata = CFG_DW'(r_def_lvl);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // per-sample update
    // ------------------------------------------------------------------
    assign i_in.ready = (r_state == ST_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign s          = i_in.sample;

    assign elapsed_sum = {1'b0, r_elapsed} + (TIME_W+1)'(r_period);
    // elapsed time saturates
    assign elapsed_inc = elapsed_sum[TIME_W] ? '1 : elapsed_sum[TIME_W-1:0];

    assign s_lo     = s < r_thr;
    assign s_hi     = s > r_thr;
    assign trough_a = (s_lo && elapsed_inc > r_guard && s < r_trough) ? s : r_trough;
    assign peak_a   = (s_hi && s > r_peak) ? s : r_peak;

    assign beat  = (elapsed_inc > TIME_W'(r_refr)) && s_hi && !r_in_pulse
                   && (elapsed_inc > r_guard);
    // first beat after reset or timeout is not counted and only starts the interval
    assign first = beat && r_await_first;
    assign fall  = s_lo && r_in_pulse;
    assign tout  = (elapsed_inc > TIME_W'(r_timeout)) && !first;

    assign amp_f   = (peak_a >= trough_a) ? (peak_a - trough_a) : '0;
    assign thr_sum = (SAMPLE_W+1)'(amp_f >> 1) + (SAMPLE_W+1)'(trough_a);
    assign thr_f   = thr_sum[SAMPLE_W-1:0];

    // ------------------------------------------------------------------
    // restoring divider step, one quotient bit a cycle
    // ------------------------------------------------------------------
    assign div_trial = {r_rem, r_quo[DIV_W-1]};
    assign div_ge    = div_trial >= {1'b0, r_dsor};
    assign n_rem     = div_ge ? TIME_W'(div_trial - {1'b0, r_dsor}) : div_trial[TIME_W-1:0];
    assign quo_lo    = r_quo[TIME_W-1:0];
    assign guard3    = {2'b00, quo_lo} + {1'b0, quo_lo, 1'b0};

    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        sum_start    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && beat) begin
                    div_start    = 1'b1;
                    div_dividend = DIV_W'(elapsed_inc);
                    div_divisor  = TIME_W'(GUARD_DIV);
                end
            end
            ST_GUARD: begin
                sum_start = (r_dcnt == '0) && r_found;
            end
            ST_SUM: begin
                if (r_hcnt == '0) begin
                    div_start    = 1'b1;
                    div_dividend = r_acc;
                    div_divisor  = TIME_W'(HIST_DEPTH);
                end
            end
            ST_MEAN: begin
                if (r_dcnt == '0 && quo_lo != '0) begin
                    div_start    = 1'b1;
                    div_dividend = DIV_W'(MS_PER_MINUTE);
                    div_divisor  = quo_lo;
                end
            end
            default: ;
        endcase
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_quo  <= div_dividend;
            r_rem  <= '0;
            r_dsor <= div_divisor;
        end else if (r_dcnt != '0) begin
            r_quo  <= {r_quo[DIV_W-2:0], div_ge};
            r_rem  <= n_rem;
        end

        if (sum_start) begin
            r_acc <= '0;
        end else if (r_state == ST_SUM && r_hcnt != '0) begin
            r_acc <= r_acc + SUM_W'(r_hist[0]);
        end

        if (in_acc && beat && !first) begin
            if (r_await_second) begin
                for (int i = 0; i < HIST_DEPTH; i++) begin
                    r_hist[i] <= elapsed_inc;
                end
            end else begin
                for (int i = 0; i < HIST_DEPTH - 1; i++) begin
                    r_hist[i] <= r_hist[i+1];
                end
                r_hist[HIST_DEPTH-1] <= elapsed_inc;
            end
        end else if (r_state == ST_SUM && r_hcnt != '0) begin
            // rotate so the line is back in order after a full pass
            for (int i = 0; i < HIST_DEPTH - 1; i++) begin
                r_hist[i] <= r_hist[i+1];
            end
            r_hist[HIST_DEPTH-1] <= r_hist[0];
        end

        if (out_load) begin
            r_obpm      <= r_rate;
            r_ofound    <= r_found;
            r_opulse    <= r_in_pulse;
            r_ointerval <= r_last;
            r_othr      <= r_thr;
            r_oamp      <= r_amp;
        end
    end

    assign out_load = (r_state == ST_DONE) && (!r_ovalid || o_out.ready);

    // ------------------------------------------------------------------
    // control and detector state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_elapsed      <= '0;
            r_last         <= RST_INTERVAL;
            r_guard        <= RST_GUARD;
            r_peak         <= RST_DEF_LVL;
            r_trough       <= RST_DEF_LVL;
            r_thr          <= RST_DEF_THR;
            r_amp          <= '0;
            r_in_pulse     <= 1'b0;
            r_await_first  <= 1'b1;
            r_await_second <= 1'b0;
            r_found        <= 1'b0;
            r_rate         <= '0;
            r_hcnt         <= '0;
            r_dcnt         <= '0;
            r_ovalid       <= 1'b0;
        end else begin
            if (div_start) begin
                r_dcnt <= DCNT_W'(DIV_W);
            end else if (r_dcnt != '0) begin
                r_dcnt <= r_dcnt - DCNT_W'(1);
            end

            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_found <= beat && !first;
                        if (beat) begin
                            r_last <= elapsed_inc;
                        end
                        r_in_pulse <= beat ? 1'b1 : (fall ? 1'b0 : r_in_pulse);
                        if (fall) begin
                            r_amp <= amp_f;
                        end

                        if (tout) begin
                            r_thr    <= r_def_thr;
                            r_peak   <= r_def_lvl;
                            r_trough <= r_def_lvl;
                        end else if (fall) begin
                            r_thr    <= thr_f;
                            r_peak   <= thr_f;
                            r_trough <= thr_f;
                        end else begin
                            r_peak   <= peak_a;
                            r_trough <= trough_a;
                        end

                        r_elapsed <= (beat || tout) ? '0 : elapsed_inc;

                        if (tout) begin
                            r_await_first  <= 1'b1;
                            r_await_second <= 1'b0;
                        end else if (first) begin
                            r_await_first  <= 1'b0;
                            r_await_second <= 1'b1;
                        end else if (beat) begin
                            r_await_second <= 1'b0;
                        end

                        r_state <= beat ? ST_GUARD : ST_DONE;
                    end
                end
                ST_GUARD: begin
                    if (r_dcnt == '0) begin
                        r_guard <= guard3[TIME_W-1:0];
                        if (r_found) begin
                            r_hcnt  <= HCNT_W'(HIST_DEPTH);
                            r_state <= ST_SUM;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_SUM: begin
                    if (r_hcnt != '0) begin
                        r_hcnt <= r_hcnt - HCNT_W'(1);
                    end else begin
                        r_state <= ST_MEAN;
                    end
                end
                ST_MEAN: begin
                    if (r_dcnt == '0) begin
                        if (quo_lo == '0) begin
                            r_rate  <= '1;
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_RATE;
                        end
                    end
                end
                ST_RATE: begin
                    if (r_dcnt == '0) begin
                        r_rate  <= quo_lo;
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out.valid           = r_ovalid;
    assign o_out.bpm             = r_obpm;
    assign o_out.beat_found      = r_ofound;
    assign o_out.pulse_active    = r_opulse;
    assign o_out.interval_ms     = r_ointerval;
    assign o_out.level_threshold = r_othr;
    assign o_out.amplitude       = r_oamp;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // the rate division never runs with a zero mean
    a_rate_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RATE) |-> (r_dsor != '0))
        else $error("rate division started with zero divisor");

    // between items the guard is 3/5 of the last interval, never above it
    a_guard_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_guard <= r_last))
        else $error("guard exceeds last interval");

    // a counted beat always goes through the history sum before its result
    a_found_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GUARD && r_dcnt == '0 && r_found) |=> (r_state == ST_SUM))
        else $error("counted beat skipped the history sum");

endmodule

// ----- sim/tb_pulse_beat_detector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pulse_beat_detector
// Streams converter samples into the beat detector through the sample
// channel, with random gaps on the input and random stalls on the result
// side. A local copy of the detector state predicts one result per sample,
// and each result is checked field by field in order. Between phases, while
// the block is idle, all registers are rewritten over the APB port and read
// back. The phases cover reset values, range extremes, frequent timeouts
// and random settings, mostly with pulse-shaped waveforms plus some noise.
// ----------------------------------------------------------------------------
module tb_pulse_beat_detector;
    import pbd_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 100;
    localparam int QUIET_LIMIT  = 4000;
    localparam int TOP_CODE     = (1 << SAMPLE_W) - 1;
    localparam int TIME_MAX     = (1 << TIME_W) - 1;
    localparam logic [CFG_IW-1:0] REG_UNUSED = REG_DEF_LVL + 3'd1;

    typedef struct packed {
        logic [TIME_W-1:0]   bpm;
        logic                beat_found;
        logic                pulse_active;
        logic [TIME_W-1:0]   interval_ms;
        logic [SAMPLE_W-1:0] level_threshold;
        logic [SAMPLE_W-1:0] amplitude;
    } t_beat_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    pbd_in_if  in_ch ();
    pbd_out_if out_ch ();

    pulse_beat_detector dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // predicted configuration
    logic [PERIOD_W-1:0] period_ms;
    logic [REFR_W-1:0]   refract_ms;
    logic [TOUT_W-1:0]   quiet_ms;
    logic [SAMPLE_W-1:0] thresh_dflt;
    logic [SAMPLE_W-1:0] level_dflt;

    // predicted detector state
    logic [TIME_W-1:0]   beat_clock;
    logic [TIME_W-1:0]   prev_interval;
    logic [SAMPLE_W-1:0] peak_seen;
    logic [SAMPLE_W-1:0] trough_seen;
    logic [SAMPLE_W-1:0] cur_thresh;
    logic [SAMPLE_W-1:0] cur_amp;
    logic [TIME_W-1:0]   cur_bpm;
    logic                above_thresh;
    logic                skip_first;
    logic                seed_next;
    logic [TIME_W-1:0]   gap_hist [HIST_DEPTH];

    logic [SAMPLE_W-1:0] pending_samples [$];
    t_beat_result        expected_results [$];
    t_beat_result        want;
    int                  mismatch_count;
    int                  quiet_cycles;
    int                  src_gap;
    int                  sink_stall;
    bit                  src_calm;
    bit                  sink_calm;

    function automatic void reset_model();
        period_ms     = RST_PERIOD;
        refract_ms    = RST_REFRACTORY;
        quiet_ms      = RST_TIMEOUT;
        thresh_dflt   = RST_DEF_THR;
        level_dflt    = RST_DEF_LVL;
        beat_clock    = '0;
        prev_interval = RST_INTERVAL;
        peak_seen     = RST_DEF_LVL;
        trough_seen   = RST_DEF_LVL;
        cur_thresh    = RST_DEF_THR;
        cur_amp       = '0;
        cur_bpm       = '0;
        above_thresh  = 1'b0;
        skip_first    = 1'b1;
        seed_next     = 1'b0;
        foreach (gap_hist[i]) gap_hist[i] = '0;
    endfunction

    // works out the result of one sample and queues it
    function automatic void predict_sample(input logic [SAMPLE_W-1:0] smp);
        int unsigned  n;
        int unsigned  guard;
        int unsigned  total;
        int unsigned  mean;
        bit           counted;
        bit           discarded;
        t_beat_result res;
        counted   = 1'b0;
        discarded = 1'b0;
        n = 32'(beat_clock) + 32'(period_ms);
        if (n > TIME_MAX) n = TIME_MAX;
        beat_clock = TIME_W'(n);
        guard = (32'(prev_interval) / GUARD_DIV) * 3;

        if (smp < cur_thresh && n > guard && smp < trough_seen) trough_seen = smp;
        if (smp > cur_thresh && smp > peak_seen) peak_seen = smp;

        if (n > 32'(refract_ms) && smp > cur_thresh && !above_thresh && n > guard) begin
            above_thresh  = 1'b1;
            prev_interval = TIME_W'(n);
            beat_clock    = '0;
            if (seed_next) begin
                seed_next = 1'b0;
                foreach (gap_hist[i]) gap_hist[i] = TIME_W'(n);
            end
            if (skip_first) begin
                // first beat only starts the interval count
                skip_first = 1'b0;
                seed_next  = 1'b1;
                discarded  = 1'b1;
            end else begin
                total = 0;
                for (int i = 0; i < HIST_DEPTH - 1; i++) begin
                    gap_hist[i] = gap_hist[i + 1];
                    total += 32'(gap_hist[i]);
                end
                gap_hist[HIST_DEPTH - 1] = TIME_W'(n);
                total += n;
                mean = total / HIST_DEPTH;
                cur_bpm = TIME_W'((mean == 0) ? TIME_MAX : MS_PER_MINUTE / mean);
                counted = 1'b1;
            end
        end

        if (!discarded) begin
            if (smp < cur_thresh && above_thresh) begin
                above_thresh = 1'b0;
                cur_amp      = (peak_seen >= trough_seen) ? peak_seen - trough_seen : '0;
                cur_thresh   = SAMPLE_W'(cur_amp / 2 + trough_seen);
                peak_seen    = cur_thresh;
                trough_seen  = cur_thresh;
            end
            // uses the time taken before a beat on this sample cleared it
            if (n > 32'(quiet_ms)) begin
                cur_thresh  = thresh_dflt;
                peak_seen   = level_dflt;
                trough_seen = level_dflt;
                beat_clock  = '0;
                skip_first  = 1'b1;
                seed_next   = 1'b0;
            end
        end

        res.bpm             = cur_bpm;
        res.beat_found      = counted;
        res.pulse_active    = above_thresh;
        res.interval_ms     = prev_interval;
        res.level_threshold = cur_thresh;
        res.amplitude       = cur_amp;
        expected_results.push_back(res);
    endfunction

    function automatic logic [CFG_DW-1:0] field_mask(input logic [CFG_IW-1:0] idx);
        case (idx)
            REG_PERIOD:     return (1 << PERIOD_W) - 1;
            REG_REFRACTORY: return (1 << REFR_W) - 1;
            REG_TIMEOUT:    return (1 << TOUT_W) - 1;
            REG_DEF_THR:    return (1 << SAMPLE_W) - 1;
            REG_DEF_LVL:    return (1 << SAMPLE_W) - 1;
            default:        return '0;
        endcase
    endfunction

    function automatic void store_register(input logic [CFG_IW-1:0] idx,
                                           input logic [CFG_DW-1:0] data);
        case (idx)
            REG_PERIOD:     period_ms   = data[PERIOD_W-1:0];
            REG_REFRACTORY: refract_ms  = data[REFR_W-1:0];
            REG_TIMEOUT:    quiet_ms    = data[TOUT_W-1:0];
            REG_DEF_THR:    thresh_dflt = data[SAMPLE_W-1:0];
            REG_DEF_LVL:    level_dflt  = data[SAMPLE_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [CFG_DW-1:0] register_value(input logic [CFG_IW-1:0] idx);
        case (idx)
            REG_PERIOD:     return CFG_DW'(period_ms);
            REG_REFRACTORY: return CFG_DW'(refract_ms);
            REG_TIMEOUT:    return CFG_DW'(quiet_ms);
            REG_DEF_THR:    return CFG_DW'(thresh_dflt);
            REG_DEF_LVL:    return CFG_DW'(level_dflt);
            default:        return '0;
        endcase
    endfunction

    function automatic void check_field(input string what, input logic [TIME_W-1:0] exp_val,
                                        input logic [TIME_W-1:0] got_val);
        if (got_val !== exp_val) begin
            $display("%0t: %s expected %0d, got %0d", $time, what, exp_val, got_val);
            mismatch_count++;
        end
    endfunction

    // mostly short gaps, a few long ones, none at all while calm
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(40, 150);
    endfunction

    function automatic void add_noise(input int count);
        repeat (count) pending_samples.push_back(SAMPLE_W'($urandom_range(0, TOP_CODE)));
    endfunction

    // pulse-shaped waveform: low baseline, a short high top, then back down;
    // some beats are replaced by noise or lose their top
    function automatic void add_pulses(input int count, input int unsigned ms_lo,
                                       input int unsigned ms_hi, input int unsigned base_hi,
                                       input int unsigned top_lo);
        int unsigned per;
        int unsigned span;
        int unsigned high;
        int          kind;
        int          added;
        per   = (period_ms == 0) ? 1 : 32'(period_ms);
        added = 0;
        while (added < count) begin
            span = $urandom_range(ms_lo, ms_hi) / per;
            if (span < 4) span = 4;
            high = $urandom_range(1, 4);
            kind = $urandom_range(0, 99);
            for (int k = 0; k < span; k++) begin
                if (kind < 8)
                    pending_samples.push_back(SAMPLE_W'($urandom_range(0, TOP_CODE)));
                else if (k < span - high || kind < 13)
                    pending_samples.push_back(SAMPLE_W'($urandom_range(0, base_hi)));
                else
                    pending_samples.push_back(SAMPLE_W'($urandom_range(top_lo, TOP_CODE)));
            end
            added += span;
        end
    endfunction

    task automatic cfg_write(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        store_register(idx, data);
    endtask

    task automatic cfg_read(input logic [CFG_IW-1:0] idx);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== register_value(idx)) begin
            $display("%0t: register %0d expected %0d, got %0d", $time, idx,
                     register_value(idx), prdata);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // upper bits get random junk that the register must drop
    task automatic write_and_check(input logic [CFG_IW-1:0] idx, input int unsigned value);
        logic [CFG_DW-1:0] data;
        data = $urandom();
        data = (data & ~field_mask(idx)) | (value & field_mask(idx));
        cfg_write(idx, data);
        cfg_read(idx);
    endtask

    task automatic settle();
        while (pending_samples.size() != 0 || expected_results.size() != 0 || in_ch.valid)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_config(input int unsigned per, input int unsigned refr,
                                input int unsigned tout, input int unsigned thr,
                                input int unsigned lvl);
        settle();
        write_and_check(REG_PERIOD, per);
        write_and_check(REG_REFRACTORY, refr);
        write_and_check(REG_TIMEOUT, tout);
        write_and_check(REG_DEF_THR, thr);
        write_and_check(REG_DEF_LVL, lvl);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // sample driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) predict_sample(in_ch.sample);
            if (!in_ch.valid || in_ch.ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    in_ch.valid <= 1'b0;
                end else if (pending_samples.size() != 0) begin
                    in_ch.valid  <= 1'b1;
                    in_ch.sample <= pending_samples.pop_front();
                    if ($urandom_range(0, 99) == 0) src_calm = !src_calm;
                    src_gap = pick_gap(src_calm);
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            sink_stall = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result item with none expected, bpm %0d", $time, out_ch.bpm);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("bpm", want.bpm, out_ch.bpm);
                    check_field("beat_found", TIME_W'(want.beat_found),
                                TIME_W'(out_ch.beat_found));
                    check_field("pulse_active", TIME_W'(want.pulse_active),
                                TIME_W'(out_ch.pulse_active));
                    check_field("interval_ms", want.interval_ms, out_ch.interval_ms);
                    check_field("level_threshold", TIME_W'(want.level_threshold),
                                TIME_W'(out_ch.level_threshold));
                    check_field("amplitude", TIME_W'(want.amplitude),
                                TIME_W'(out_ch.amplitude));
                end
            end
            if (sink_stall > 0) begin
                sink_stall--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(0, 99) == 0) sink_calm = !sink_calm;
                sink_stall = pick_gap(sink_calm);
            end
        end
    end

    // watchdog: ends a run that stops moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (psel && penable && pready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_pulse_beat_detector: done, errors");
                $finish;
            end
        end
    end

    initial begin
        mismatch_count = 0;
        src_calm       = 1'b0;
        sink_calm      = 1'b0;
        reset_model();
        i_rst_n      <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: sample extremes, bit patterns, values around the threshold
        pending_samples = '{10'd0, 10'd1023, 10'h155, 10'h2AA, 10'd529, 10'd530, 10'd531,
                            10'd512, 10'd511, 10'd513, 10'd1, 10'd1022};

        // fast beats
        apply_config(15, 100, 2500, 530, 512);
        cfg_write(REG_UNUSED, $urandom());
        add_pulses(260, 300, 700, 450, 600);

        // lowest nonzero period, no refractory time, longest timeout
        apply_config(1, 0, 32767, 0, 0);
        add_pulses(220, 60, 200, 400, 650);

        // short timeout, so beats and timeouts meet
        apply_config(15, 100, 400, 530, 512);
        add_pulses(200, 200, 600, 450, 600);

        // threshold at the top: timeouts but no beats
        apply_config(15, 4095, 300, 1023, 1023);
        add_noise(40);

        // timeout on every sample
        apply_config(15, 0, 0, 0, 0);
        add_noise(30);

        // zero period: elapsed time stands still
        apply_config(0, 0, 0, $urandom_range(0, TOP_CODE), $urandom_range(0, TOP_CODE));
        add_noise(30);

        repeat (3) begin
            apply_config($urandom_range(6, 15), $urandom_range(0, 300),
                         $urandom_range(400, 3000), $urandom_range(300, 700),
                         $urandom_range(0, TOP_CODE));
            add_pulses(130, 150, 700, $urandom_range(250, 500), $urandom_range(550, 750));
            add_noise(20);
        end

        settle();
        if (mismatch_count == 0) begin
            $display("tb_pulse_beat_detector: done, clean");
        end else begin
            $display("tb_pulse_beat_detector: done, errors");
        end
        $finish;
    end

endmodule
